// ----- design/linked_list_move_swap_reverse_defines.svh -----
// Assertion macros for the linked list move/swap/reverse block.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef LINKED_LIST_MOVE_SWAP_REVERSE_DEFINES_SVH
`define LINKED_LIST_MOVE_SWAP_REVERSE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLMSR_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLMSR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/llmsr_pkg.sv -----
// Package for the linked list move/swap/reverse block: field widths, request codes,
// sequencer types and the microprogram ROM. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package llmsr_pkg;

	localparam int BOX_W   = 10;
	localparam int REQ_W   = 3;
	localparam int SUM_W   = 19;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam int UPC_W   = 6;

	localparam logic [BOX_W-1:0] NUM_BOXES_RST = 10'd1023;
	localparam logic             REG_NUM_BOXES = 1'b0;

	localparam logic [REQ_W-1:0] REQ_RESTART = 3'd0;
	localparam logic [REQ_W-1:0] REQ_BEFORE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_AFTER   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SWAP    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd4;
	localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd5;

	typedef enum logic {
		SQ_IDLE,
		SQ_RUN
	} seq_state_t;

	typedef enum logic [1:0] {
		RD_A,
		RD_B,
		RD_ZERO,
		RD_PTR
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_A,
		S_B,
		S_PA,
		S_NA,
		S_PB,
		S_NB,
		S_PBX,
		S_NBX,
		S_CNT,
		S_CNTNXT
	} src_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_PB_IS_A,
		C_NB_IS_A,
		C_NA_IS_B,
		C_RST_MORE,
		C_WALK_MORE
	} cond_t;

	typedef struct packed {
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic             end_f;
		rd_sel_t          rd;
		logic             ld_a;
		logic             ld_b;
		logic             wr;
		src_t             l;
		src_t             r;
		logic             inc_cnt;
		logic             clr_rev;
		logic             init_walk;
		logic             walk;
		logic             emit;
	} ucw_t;

	localparam logic [UPC_W-1:0] UP_BEFORE  = 6'd0;
	localparam logic [UPC_W-1:0] UP_AFTER   = 6'd7;
	localparam logic [UPC_W-1:0] UP_SWAP    = 6'd14;
	localparam logic [UPC_W-1:0] UP_SW_BA   = 6'd23;
	localparam logic [UPC_W-1:0] UP_SW_AB   = 6'd26;
	localparam logic [UPC_W-1:0] UP_RESTART = 6'd29;
	localparam logic [UPC_W-1:0] UP_QUERY   = 6'd30;
	localparam logic [UPC_W-1:0] UP_WALK    = 6'd31;
	localparam logic [UPC_W-1:0] UP_EMIT    = 6'd32;
	localparam logic [UPC_W-1:0] UP_DONE    = 6'd33;

	localparam ucw_t UCW_NOP = '{
		cond: C_NONE, target: '0, end_f: 1'b0, rd: RD_A, ld_a: 1'b0, ld_b: 1'b0,
		wr: 1'b0, l: S_A, r: S_A, inc_cnt: 1'b0, clr_rev: 1'b0, init_walk: 1'b0,
		walk: 1'b0, emit: 1'b0
	};

	// Each write step joins two entries: next[l] = r and prev[r] = l.
	function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
		ucw_t w;
		w = UCW_NOP;
		unique case (upc)
			UP_BEFORE: begin
				w.rd = RD_A;
			end
			UP_BEFORE + 6'd1: begin
				w.rd = RD_B; w.ld_a = 1'b1;
			end
			UP_BEFORE + 6'd2: begin
				w.ld_b = 1'b1;
			end
			UP_BEFORE + 6'd3: begin
				w.cond = C_PB_IS_A; w.target = UP_DONE;
			end
			UP_BEFORE + 6'd4: begin
				w.wr = 1'b1; w.l = S_PA; w.r = S_NA;
			end
			UP_BEFORE + 6'd5: begin
				w.wr = 1'b1; w.l = S_PBX; w.r = S_A;
			end
			UP_BEFORE + 6'd6: begin
				w.wr = 1'b1; w.l = S_A; w.r = S_B; w.end_f = 1'b1;
			end
			UP_AFTER: begin
				w.rd = RD_A;
			end
			UP_AFTER + 6'd1: begin
				w.rd = RD_B; w.ld_a = 1'b1;
			end
			UP_AFTER + 6'd2: begin
				w.ld_b = 1'b1;
			end
			UP_AFTER + 6'd3: begin
				w.cond = C_NB_IS_A; w.target = UP_DONE;
			end
			UP_AFTER + 6'd4: begin
				w.wr = 1'b1; w.l = S_PA; w.r = S_NA;
			end
			UP_AFTER + 6'd5: begin
				w.wr = 1'b1; w.l = S_A; w.r = S_NBX;
			end
			UP_AFTER + 6'd6: begin
				w.wr = 1'b1; w.l = S_B; w.r = S_A; w.end_f = 1'b1;
			end
			UP_SWAP: begin
				w.rd = RD_A;
			end
			UP_SWAP + 6'd1: begin
				w.rd = RD_B; w.ld_a = 1'b1;
			end
			UP_SWAP + 6'd2: begin
				w.ld_b = 1'b1;
			end
			UP_SWAP + 6'd3: begin
				w.cond = C_NB_IS_A; w.target = UP_SW_BA;
			end
			UP_SWAP + 6'd4: begin
				w.cond = C_NA_IS_B; w.target = UP_SW_AB;
			end
			UP_SWAP + 6'd5: begin
				w.wr = 1'b1; w.l = S_PA; w.r = S_B;
			end
			UP_SWAP + 6'd6: begin
				w.wr = 1'b1; w.l = S_B; w.r = S_NA;
			end
			UP_SWAP + 6'd7: begin
				w.wr = 1'b1; w.l = S_PB; w.r = S_A;
			end
			UP_SWAP + 6'd8: begin
				w.wr = 1'b1; w.l = S_A; w.r = S_NB; w.end_f = 1'b1;
			end
			UP_SW_BA: begin
				w.wr = 1'b1; w.l = S_B; w.r = S_NA;
			end
			UP_SW_BA + 6'd1: begin
				w.wr = 1'b1; w.l = S_PB; w.r = S_A;
			end
			UP_SW_BA + 6'd2: begin
				w.wr = 1'b1; w.l = S_A; w.r = S_B; w.end_f = 1'b1;
			end
			UP_SW_AB: begin
				w.wr = 1'b1; w.l = S_A; w.r = S_NB;
			end
			UP_SW_AB + 6'd1: begin
				w.wr = 1'b1; w.l = S_PA; w.r = S_B;
			end
			UP_SW_AB + 6'd2: begin
				w.wr = 1'b1; w.l = S_B; w.r = S_A; w.end_f = 1'b1;
			end
			UP_RESTART: begin
				w.wr = 1'b1; w.l = S_CNT; w.r = S_CNTNXT; w.inc_cnt = 1'b1;
				w.cond = C_RST_MORE; w.target = UP_RESTART; w.end_f = 1'b1;
				w.clr_rev = 1'b1;
			end
			UP_QUERY: begin
				w.rd = RD_ZERO; w.init_walk = 1'b1;
			end
			UP_WALK: begin
				w.rd = RD_PTR; w.walk = 1'b1; w.cond = C_WALK_MORE; w.target = UP_WALK;
			end
			UP_EMIT: begin
				w.emit = 1'b1; w.end_f = 1'b1;
			end
			UP_DONE: begin
				w.end_f = 1'b1;
			end
			default: begin
				w.end_f = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- design/llmsr_channels.sv -----
// Request and result channel interfaces of the linked list move/swap/reverse block.
// Depends on llmsr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface llmsr_req_if;
	import llmsr_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [BOX_W-1:0] box_a;
	logic [BOX_W-1:0] box_b;

	modport source(output valid, req_type, box_a, box_b, input ready);
	modport sink(input valid, req_type, box_a, box_b, output ready);
endinterface

interface llmsr_res_if;
	import llmsr_pkg::*;

	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] odd_position_sum;

	modport source(output valid, odd_position_sum, input ready);
	modport sink(input valid, odd_position_sum, output ready);
endinterface

`default_nettype wire

// ----- design/linked_list_move_swap_reverse.sv -----
// Circular doubly linked list of entries with move, swap, reverse and odd-position query.
// Depends on llmsr_pkg, the channel interfaces and linked_list_move_swap_reverse_defines.svh.
// One request is worked at a time by a microcoded sequencer over the prev/next link
// memories, one memory access each per cycle. Reverse and ignored requests are finished in
// the cycle in which they are accepted. Any other request then runs its steps: a move takes
// 7 steps (5 when already in place), a swap 7 to 9, a restart N+1 with one link pair
// written per step, and a query L+3 for a list of L entries with one link followed per
// step. The last step of a query waits while the output register still holds a result
// that has not been taken. The next request is taken in the cycle after the last step, and
// a query result waits in the output register while new requests go on.
`timescale 1ns / 1ps
`default_nettype none
`include "linked_list_move_swap_reverse_defines.svh"

module linked_list_move_swap_reverse #(
	parameter int MAX_BOXES = 1023
) (
	input  wire                             clk,
	input  wire                             arst_n,
	llmsr_req_if.sink                       req,
	llmsr_res_if.source                     res,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire [llmsr_pkg::PADDR_W-1:0]    paddr,
	input  wire [llmsr_pkg::DATA_W-1:0]     pwdata,
	output logic [llmsr_pkg::DATA_W-1:0]    prdata,
	output logic                            pready
);
	import llmsr_pkg::*;

	localparam int LW = $clog2(MAX_BOXES + 1);
	localparam int PW = $clog2(MAX_BOXES + 2);

	seq_state_t       state_q, state_d;
	logic [UPC_W-1:0] upc_q, upc_d;
	logic             rev_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	logic [BOX_W-1:0] num_boxes_q;

	logic [LW-1:0] prev_mem [0:MAX_BOXES];
	logic [LW-1:0] next_mem [0:MAX_BOXES];
	logic [LW-1:0] prev_rd_q, next_rd_q;

	logic [LW-1:0]    a_q, b_q, pa_q, na_q, pb_q, nb_q, cnt_q;
	logic [PW-1:0]    pos_q;
	logic [SUM_W-1:0] sum_q;

	ucw_t             uc;
	logic             running, req_fire, cfg_wr, boxes_ok, cond_true, jump, stall, emit_fire;
	logic             walk_more;
	logic [REQ_W-1:0] op_map;
	logic [BOX_W-1:0] n_box;
	logic [LW-1:0]    n_l, cnt_nxt, join_l, join_r, rd_addr, pbx, nbx;
	logic [BOX_W:0]   n_inc;
	logic [20:0]      total_prod;
	logic [SUM_W-1:0] fin_sum;

	assign uc       = ucode(upc_q);
	assign running  = (state_q == SQ_RUN);
	assign req.ready = (state_q == SQ_IDLE);
	assign req_fire = req.valid && req.ready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[PADDR_W-1] == REG_NUM_BOXES) ?
		{{(DATA_W-BOX_W){1'b0}}, num_boxes_q} : '0;

	assign n_box = (int'(num_boxes_q) > MAX_BOXES) ? BOX_W'(MAX_BOXES) : num_boxes_q;
	assign n_l   = LW'(n_box);

	assign boxes_ok = (req.box_a != '0) && (req.box_b != '0) && (req.box_a <= n_box) &&
		(req.box_b <= n_box) && (req.box_a != req.box_b);
	assign op_map = !rev_q ? req.req_type :
		(req.req_type == REQ_BEFORE) ? REQ_AFTER :
		(req.req_type == REQ_AFTER) ? REQ_BEFORE : req.req_type;

	assign pbx     = (b_q == na_q) ? pa_q : pb_q;
	assign nbx     = (b_q == pa_q) ? na_q : nb_q;
	assign cnt_nxt = (cnt_q == n_l) ? '0 : cnt_q + LW'(1);

	assign walk_more = (next_rd_q != '0) && (pos_q <= PW'(MAX_BOXES));

	assign n_inc      = {1'b0, n_box} + {{BOX_W{1'b0}}, 1'b1};
	assign total_prod = {{(21-BOX_W){1'b0}}, n_box} * {{(20-BOX_W){1'b0}}, n_inc};
	assign fin_sum    = (rev_q && !n_box[0]) ? (total_prod[SUM_W:1] - sum_q) : sum_q;

	function automatic logic [LW-1:0] pick(input src_t sel);
		logic [LW-1:0] v;
		case (sel)
			S_A:      v = a_q;
			S_B:      v = b_q;
			S_PA:     v = pa_q;
			S_NA:     v = na_q;
			S_PB:     v = pb_q;
			S_NB:     v = nb_q;
			S_PBX:    v = pbx;
			S_NBX:    v = nbx;
			S_CNT:    v = cnt_q;
			S_CNTNXT: v = cnt_nxt;
			default:  v = a_q;
		endcase
		return v;
	endfunction

	assign join_l = pick(uc.l);
	assign join_r = pick(uc.r);

	always_comb begin
		case (uc.rd)
			RD_A:    rd_addr = a_q;
			RD_B:    rd_addr = b_q;
			RD_ZERO: rd_addr = '0;
			RD_PTR:  rd_addr = next_rd_q;
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		case (uc.cond)
			C_NONE:      cond_true = 1'b0;
			C_PB_IS_A:   cond_true = (pb_q == a_q);
			C_NB_IS_A:   cond_true = (nb_q == a_q);
			C_NA_IS_B:   cond_true = (na_q == b_q);
			C_RST_MORE:  cond_true = (cnt_q != n_l);
			C_WALK_MORE: cond_true = walk_more;
			default:     cond_true = 1'b0;
		endcase
	end

	assign jump      = running && cond_true;
	assign stall     = running && uc.emit && out_valid_q && !res.ready;
	assign emit_fire = running && uc.emit && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			upc_q   <= UP_DONE;
		end else begin
			state_q <= state_d;
			upc_q   <= upc_d;
		end
	end

	always_comb begin
		state_d = state_q;
		upc_d   = upc_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (req_fire) begin
					unique case (req.req_type) inside
						REQ_RESTART: begin
							state_d = SQ_RUN;
							upc_d   = UP_RESTART;
						end
						REQ_QUERY: begin
							state_d = SQ_RUN;
							upc_d   = UP_QUERY;
						end
						REQ_BEFORE, REQ_AFTER, REQ_SWAP: begin
							if (boxes_ok) begin
								state_d = SQ_RUN;
								upc_d   = (op_map == REQ_BEFORE) ? UP_BEFORE :
									(op_map == REQ_AFTER) ? UP_AFTER : UP_SWAP;
							end
						end
						default: begin
							state_d = SQ_IDLE;
						end
					endcase
				end
			end
			SQ_RUN: begin
				if (!stall) begin
					if (jump) begin
						upc_d = uc.target;
					end else if (uc.end_f) begin
						state_d = SQ_IDLE;
					end else begin
						upc_d = upc_q + UPC_W'(1);
					end
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
			num_boxes_q <= NUM_BOXES_RST;
		end else begin
			if (req_fire && (req.req_type == REQ_REVERSE)) begin
				rev_q <= !rev_q;
			end else if (running && uc.clr_rev) begin
				rev_q <= 1'b0;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && (paddr[PADDR_W-1] == REG_NUM_BOXES)) begin
				num_boxes_q <= pwdata[BOX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prev_rd_q <= prev_mem[rd_addr];
		next_rd_q <= next_mem[rd_addr];
		if (running && uc.wr) begin
			next_mem[join_l] <= join_r;
			prev_mem[join_r] <= join_l;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			a_q   <= LW'(req.box_a);
			b_q   <= LW'(req.box_b);
			cnt_q <= '0;
		end else if (running && uc.inc_cnt) begin
			cnt_q <= cnt_q + LW'(1);
		end
		if (running && uc.ld_a) begin
			pa_q <= prev_rd_q;
			na_q <= next_rd_q;
		end
		if (running && uc.ld_b) begin
			pb_q <= prev_rd_q;
			nb_q <= next_rd_q;
		end
		if (running && uc.init_walk) begin
			sum_q <= '0;
			pos_q <= PW'(1);
		end else if (running && uc.walk && walk_more) begin
			if (pos_q[0]) begin
				sum_q <= sum_q + SUM_W'(next_rd_q);
			end
			pos_q <= pos_q + PW'(1);
		end
		if (emit_fire) begin
			out_sum_q <= fin_sum;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.odd_position_sum = out_sum_q;

	`LLMSR_ASSERT_IMP(a_result_from_emit, $rose(res.valid), $past(running && uc.emit), "result raised outside the emit step")
	`LLMSR_ASSERT_IMP(a_restart_in_range, running && uc.inc_cnt, cnt_q <= n_l, "restart counter ran past the list size")
	`LLMSR_ASSERT_NXT(a_restart_clears_rev, running && uc.clr_rev && !jump, !rev_q, "restart left the list reversed")

endmodule

`default_nettype wire
